// ===== sv/ghc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ghc_pkg;

    // field widths fixed by the stream format
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;

    // command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // reset value of both size registers
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [POS_W-1:0] cell_row;
        logic [POS_W-1:0] cell_col;
        logic [VAL_W-1:0] cell_value;
    } ghc_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] path_value;
        logic [POS_W-1:0] pos_row;
        logic [POS_W-1:0] pos_col;
        logic             at_peak;
    } ghc_res_t;

endpackage

`default_nettype wire

// ===== sv/grid_hill_climb.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                      Contents
// s_axis    in         s_tvalid/s_tready/s_tdata    one command per transfer
//                      s_tuser                      cmd
// m_axis    out        m_tvalid/m_tready/m_tdata    one result per command
//                      m_tuser                      at_peak
// cfg       in         cfg_we/cfg_addr/cfg_wdata    row_count, col_count
//
// A step runs through setup, one read of the grid memory per window cell (up to
// nine) through its single read port, the registered read data, a decision
// state and the result hand-off.
// Reset clears the position to the origin and both size registers to 64; the
// grid memory is not cleared and holds no value until written.
// A new command is taken while an earlier result still waits on m_axis; the
// engine stalls only when a second result is ready before the first leaves.

module grid_hill_climb #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // cell_row[5:0], cell_col[11:6],
                                        // cell_value[43:12], zero fill
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // path_value[31:0], pos_row[37:32],
                                        // pos_col[43:38], zero fill
    output logic             m_tuser,   // at_peak[0]
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [6:0]  cfg_wdata
);

    import ghc_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    ghc_res_t         out_reg;
    ghc_req_t         req;
    ghc_res_t         res;
    logic             start;
    logic             ready;
    logic             res_valid;
    logic             res_ack;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [31:0]      mem_rdata;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_RESET;
            col_count_reg <= CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ROW_COUNT: row_count_reg <= cfg_wdata;
                REG_COL_COUNT: col_count_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // unpack the command
    assign req.cmd        = s_tuser;
    assign req.cell_row   = s_tdata[5:0];
    assign req.cell_col   = s_tdata[11:6];
    assign req.cell_value = s_tdata[43:12];

    assign s_tready = ready;
    assign start    = s_tvalid && ready;

    // load the output register when it is empty or being drained
    assign res_ack       = res_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid_next = res_ack ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_reg.pos_col, out_reg.pos_row, out_reg.path_value};
    assign m_tuser  = out_reg.at_peak;

    ghc_climb #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_climb (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .ready     (ready),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ghc_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== sv/ghc_grid_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ghc_grid_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one read port, registered data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ghc_climb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ghc_climb #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int AW       = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire ghc_pkg::ghc_req_t        req,
    input  wire logic [ghc_pkg::CNT_W-1:0] row_count,
    input  wire logic [ghc_pkg::CNT_W-1:0] col_count,
    output logic                          ready,
    output logic                          res_valid,
    input  wire logic                     res_ack,
    output ghc_pkg::ghc_res_t             res,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [31:0]                   mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  wire logic [31:0]              mem_rdata
);

    import ghc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam int TOP_R = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int TOP_C = (MAX_COLS < 64) ? MAX_COLS : 64;

    function automatic logic [AW-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                input logic [POS_W-1:0] c);
        logic [31:0] lin;
        lin = {26'b0, r} * 32'(MAX_COLS) + {26'b0, c};
        return lin[AW-1:0];
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [POS_W-1:0]   cur_row_reg, cur_row_next;
    logic [POS_W-1:0]   cur_col_reg, cur_col_next;
    logic [POS_W-1:0]   c0_reg, c0_next;
    logic [POS_W-1:0]   r1_reg, r1_next;
    logic [POS_W-1:0]   c1_reg, c1_next;
    logic [POS_W-1:0]   ir_reg, ir_next;
    logic [POS_W-1:0]   ic_reg, ic_next;
    logic               issue_reg, issue_next;
    logic               first_reg, first_next;
    logic               restart_reg, restart_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               rd_first_reg, rd_first_next;
    logic               rd_here_reg, rd_here_next;
    logic               rd_last_reg, rd_last_next;
    logic [POS_W-1:0]   rd_r_reg, rd_r_next;
    logic [POS_W-1:0]   rd_c_reg, rd_c_next;
    logic signed [31:0] best_reg, best_next;
    logic signed [31:0] here_reg, here_next;
    logic [POS_W-1:0]   best_r_reg, best_r_next;
    logic [POS_W-1:0]   best_c_reg, best_c_next;
    ghc_res_t           res_reg, res_next;

    logic [CNT_W-1:0]   rows, cols, sr, sc;
    logic               in_store;
    logic               last_issue;
    logic signed [31:0] rd_val;

    // clamp the size registers and bound the window around the position
    always_comb
    begin
        rows = (row_count == '0) ? 7'd1 :
               (row_count > 7'(TOP_R)) ? 7'(TOP_R) : row_count;
        cols = (col_count == '0) ? 7'd1 :
               (col_count > 7'(TOP_C)) ? 7'(TOP_C) : col_count;
        sr   = ({1'b0, cur_row_reg} >= rows) ? rows - 7'd1 : {1'b0, cur_row_reg};
        sc   = ({1'b0, cur_col_reg} >= cols) ? cols - 7'd1 : {1'b0, cur_col_reg};
    end

    assign in_store   = ({26'b0, req.cell_row} < 32'(MAX_ROWS)) &&
                        ({26'b0, req.cell_col} < 32'(MAX_COLS));
    assign last_issue = (ir_reg == r1_reg) && (ic_reg == c1_reg);
    assign rd_val     = $signed(mem_rdata);

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // grid write happens on the transfer itself
    assign mem_we    = start && (req.cmd == CMD_WRITE) && in_store;
    assign mem_waddr = cell_addr(req.cell_row, req.cell_col);
    assign mem_wdata = req.cell_value;
    assign mem_re    = (state_reg == ST_SCAN) && issue_reg;
    assign mem_raddr = cell_addr(ir_reg, ic_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        c0_next       = c0_reg;
        r1_next       = r1_reg;
        c1_next       = c1_reg;
        ir_next       = ir_reg;
        ic_next       = ic_reg;
        issue_next    = issue_reg;
        first_next    = first_reg;
        restart_next  = restart_reg;
        rd_vld_next   = 1'b0;
        rd_first_next = rd_first_reg;
        rd_here_next  = rd_here_reg;
        rd_last_next  = rd_last_reg;
        rd_r_next     = rd_r_reg;
        rd_c_next     = rd_c_reg;
        best_next     = best_reg;
        here_next     = here_reg;
        best_r_next   = best_r_reg;
        best_c_next   = best_c_reg;
        res_next      = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.cmd)
                        CMD_STEP:
                        begin
                            restart_next = 1'b0;
                            state_next   = ST_SETUP;
                        end
                        CMD_RESTART:
                        begin
                            // a one-cell window at the origin
                            restart_next = 1'b1;
                            cur_row_next = '0;
                            cur_col_next = '0;
                            ir_next      = '0;
                            ic_next      = '0;
                            c0_next      = '0;
                            r1_next      = '0;
                            c1_next      = '0;
                            issue_next   = 1'b1;
                            first_next   = 1'b1;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            // write and unused code answer at once
                            res_next.path_value = '0;
                            res_next.pos_row    = cur_row_reg;
                            res_next.pos_col    = cur_col_reg;
                            res_next.at_peak    = 1'b0;
                            state_next          = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                // saturate the position and open the window
                cur_row_next = sr[POS_W-1:0];
                cur_col_next = sc[POS_W-1:0];
                ir_next      = (sr == '0) ? '0 : 6'(sr - 7'd1);
                ic_next      = (sc == '0) ? '0 : 6'(sc - 7'd1);
                c0_next      = (sc == '0) ? '0 : 6'(sc - 7'd1);
                r1_next      = (sr + 7'd1 < rows) ? 6'(sr + 7'd1) : 6'(rows - 7'd1);
                c1_next      = (sc + 7'd1 < cols) ? 6'(sc + 7'd1) : 6'(cols - 7'd1);
                issue_next   = 1'b1;
                first_next   = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                // issue one read a cycle in row-major window order
                if (issue_reg)
                begin
                    rd_vld_next   = 1'b1;
                    rd_first_next = first_reg;
                    rd_here_next  = (ir_reg == cur_row_reg) && (ic_reg == cur_col_reg);
                    rd_last_next  = last_issue;
                    rd_r_next     = ir_reg;
                    rd_c_next     = ic_reg;
                    first_next    = 1'b0;
                    if (last_issue)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (ic_reg == c1_reg)
                    begin
                        ic_next = c0_reg;
                        ir_next = ir_reg + 6'd1;
                    end
                    else
                    begin
                        ic_next = ic_reg + 6'd1;
                    end
                end
                // fold the returned cell into the running maximum
                if (rd_vld_reg)
                begin
                    if (rd_first_reg || (rd_val > best_reg))
                    begin
                        best_next   = rd_val;
                        best_r_next = rd_r_reg;
                        best_c_next = rd_c_reg;
                    end
                    if (rd_here_reg)
                    begin
                        here_next = rd_val;
                    end
                    if (rd_last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                // move only on a strictly larger neighbour
                if (restart_reg)
                begin
                    res_next.path_value = here_reg;
                    res_next.pos_row    = cur_row_reg;
                    res_next.pos_col    = cur_col_reg;
                    res_next.at_peak    = 1'b0;
                end
                else if (best_reg > here_reg)
                begin
                    cur_row_next        = best_r_reg;
                    cur_col_next        = best_c_reg;
                    res_next.path_value = best_reg;
                    res_next.pos_row    = best_r_reg;
                    res_next.pos_col    = best_c_reg;
                    res_next.at_peak    = 1'b0;
                end
                else
                begin
                    res_next.path_value = here_reg;
                    res_next.pos_row    = cur_row_reg;
                    res_next.pos_col    = cur_col_reg;
                    res_next.at_peak    = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            issue_reg   <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            issue_reg   <= issue_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    // window, scan and result payload
    always_ff @(posedge clk)
    begin
        c0_reg       <= c0_next;
        r1_reg       <= r1_next;
        c1_reg       <= c1_next;
        ir_reg       <= ir_next;
        ic_reg       <= ic_next;
        first_reg    <= first_next;
        restart_reg  <= restart_next;
        rd_first_reg <= rd_first_next;
        rd_here_reg  <= rd_here_next;
        rd_last_reg  <= rd_last_next;
        rd_r_reg     <= rd_r_next;
        rd_c_reg     <= rd_c_next;
        best_reg     <= best_next;
        here_reg     <= here_next;
        best_r_reg   <= best_r_next;
        best_c_reg   <= best_c_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// ===== bench/grid_hill_climb_tb.sv =====
`timescale 1ns / 1ps

module grid_hill_climb_tb;
    import ghc_pkg::*;

    localparam int GRID_ROWS  = 64;
    localparam int GRID_COLS  = 64;
    localparam int CLK_HALF   = 2;
    localparam int ITEM_GOAL  = 550;
    localparam int PHASE_LEN  = 50;
    localparam int DIR_ROWS   = 22;
    localparam int PLAN_LEN   = 8;
    localparam int PRINT_CAP  = 100;
    localparam int TIMEOUT_NS = 4_000_000;

    // the fourth command code has no meaning and is answered like a write
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]       cmd;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] val;
        bit               typed;
        ghc_res_t         want;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // cell_row[5:0], cell_col[11:6], cell_value[43:12]
    logic [1:0]  s_tuser   = CMD_WRITE;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;          // path_value[31:0], pos_row[37:32], pos_col[43:38]
    logic        m_tuser;          // at_peak[0]
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = REG_ROW_COUNT;
    logic [6:0]  cfg_wdata = '0;

    // shadow of the block: grid, position and raw size registers
    logic signed [VAL_W-1:0] grid_copy [0:GRID_ROWS*GRID_COLS-1];
    bit                      cell_known [0:GRID_ROWS*GRID_COLS-1];
    int                      pos_r;
    int                      pos_c;
    logic [CNT_W-1:0]        rows_raw;
    logic [CNT_W-1:0]        cols_raw;

    ghc_res_t         pending_results [$];
    ghc_res_t         want_res;
    dir_row_t         dir_tab [0:DIR_ROWS-1];
    logic [CNT_W-1:0] plan_rows [0:PLAN_LEN-1];
    logic [CNT_W-1:0] plan_cols [0:PLAN_LEN-1];
    bit               plan_ramp [0:PLAN_LEN-1];
    int               err_count  = 0;
    int               items_sent = 0;
    bit               calm       = 1'b0;
    bit               ramp_mode  = 1'b0;

    grid_hill_climb #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (err_count < PRINT_CAP)
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
        err_count++;
    endtask

    function automatic int flat(input int r, input int c);
        return r * GRID_COLS + c;
    endfunction

    // size in use: zero reads as one, anything above the bound as the bound
    function automatic int eff_size(input logic [CNT_W-1:0] raw, input int bound);
        int top;
        top = (bound < 64) ? bound : 64;
        if (raw == 0)
            return 1;
        return (int'(raw) > top) ? top : int'(raw);
    endfunction

    // position pulled into the grid and the 3x3 window around it, clipped
    function automatic void climb_window(output int sr, output int sc,
                                         output int r0, output int r1,
                                         output int c0, output int c1);
        int rows;
        int cols;
        rows = eff_size(rows_raw, GRID_ROWS);
        cols = eff_size(cols_raw, GRID_COLS);
        sr = (pos_r >= rows) ? rows - 1 : pos_r;
        sc = (pos_c >= cols) ? cols - 1 : pos_c;
        r0 = (sr > 0) ? sr - 1 : 0;
        r1 = (sr + 1 < rows) ? sr + 1 : rows - 1;
        c0 = (sc > 0) ? sc - 1 : 0;
        c1 = (sc + 1 < cols) ? sc + 1 : cols - 1;
    endfunction

    // advance the shadow by one command and return the answer it gives
    function automatic ghc_res_t climb_predict(input logic [1:0] cmd,
                                               input logic [POS_W-1:0] row,
                                               input logic [POS_W-1:0] col,
                                               input logic [VAL_W-1:0] val);
        ghc_res_t                res;
        int                      sr, sc, r0, r1, c0, c1, br, bc;
        logic signed [VAL_W-1:0] here;
        logic signed [VAL_W-1:0] best;
        res = '0;
        case (cmd)
            CMD_WRITE:
            begin
                grid_copy[flat(row, col)]  = val;
                cell_known[flat(row, col)] = 1'b1;
            end
            CMD_RESTART:
            begin
                pos_r = 0;
                pos_c = 0;
                res.path_value = grid_copy[0];
            end
            CMD_STEP:
            begin
                climb_window(sr, sc, r0, r1, c0, c1);
                pos_r = sr;
                pos_c = sc;
                here = grid_copy[flat(sr, sc)];
                best = grid_copy[flat(r0, c0)];
                br = r0;
                bc = c0;
                // first strict maximum in row-major order wins ties
                for (int r = r0; r <= r1; r++)
                begin
                    for (int c = c0; c <= c1; c++)
                    begin
                        if (grid_copy[flat(r, c)] > best)
                        begin
                            best = grid_copy[flat(r, c)];
                            br = r;
                            bc = c;
                        end
                    end
                end
                if (best > here)
                begin
                    pos_r = br;
                    pos_c = bc;
                end
                else
                    res.at_peak = 1'b1;
                res.path_value = grid_copy[flat(pos_r, pos_c)];
            end
            default:
            begin
            end
        endcase
        res.pos_row = pos_r[POS_W-1:0];
        res.pos_col = pos_c[POS_W-1:0];
        return res;
    endfunction

    // ramp phases lay a slope toward the far corner so climbs run long
    function automatic logic [VAL_W-1:0] fresh_value(input int r, input int c);
        int pick;
        pick = $urandom_range(0, 99);
        if (ramp_mode)
            return (r + c) * 16 - 600 + $urandom_range(0, 24);
        if (pick < 55)
            return $urandom_range(0, 40) - 20;
        if (pick < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // present one command, hold until the transfer, then record its answer
    task automatic send_cmd(input logic [1:0] cmd, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [VAL_W-1:0] val,
                            input bit typed, input ghc_res_t want);
        ghc_res_t predicted;
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, val, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = climb_predict(cmd, row, col, val);
        pending_results.push_back(typed ? want : predicted);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // write every cell the command will read before issuing it
    task automatic fill_then_send(input logic [1:0] cmd);
        int sr, sc, r0, r1, c0, c1;
        r0 = 0;
        r1 = 0;
        c0 = 0;
        c1 = 0;
        if (cmd == CMD_STEP)
            climb_window(sr, sc, r0, r1, c0, c1);
        for (int r = r0; r <= r1; r++)
        begin
            for (int c = c0; c <= c1; c++)
            begin
                if (!cell_known[flat(r, c)])
                    send_cmd(CMD_WRITE, POS_W'(r), POS_W'(c), fresh_value(r, c), 1'b0, '0);
            end
        end
        send_cmd(cmd, POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                 $urandom, 1'b0, '0);
    endtask

    // drop valid and wait until every answer has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_grid_size(input logic [CNT_W-1:0] rows,
                                 input logic [CNT_W-1:0] cols);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ROW_COUNT;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_addr  <= REG_COL_COUNT;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rows_raw = rows;
        cols_raw = cols;
    endtask

    // check each result transfer against the oldest answer waiting
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", '0, m_tdata[31:0]);
            else
            begin
                want_res = pending_results.pop_front();
                if (m_tdata[31:0] !== want_res.path_value)
                    report_mismatch("path_value", want_res.path_value, m_tdata[31:0]);
                if (m_tdata[37:32] !== want_res.pos_row)
                    report_mismatch("pos_row", 32'(want_res.pos_row), 32'(m_tdata[37:32]));
                if (m_tdata[43:38] !== want_res.pos_col)
                    report_mismatch("pos_col", 32'(want_res.pos_col), 32'(m_tdata[43:38]));
                if (m_tuser !== want_res.at_peak)
                    report_mismatch("at_peak", 32'(want_res.at_peak), 32'(m_tuser));
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 33);
    end

    initial
    begin
        int               phase;
        int               phase_start;
        int               pick;
        int               wr_r;
        int               wr_c;
        logic [CNT_W-1:0] next_rows;
        logic [CNT_W-1:0] next_cols;

        pos_r    = 0;
        pos_c    = 0;
        rows_raw = CNT_RESET;
        cols_raw = CNT_RESET;

        // seed a small landscape at the origin, then climb it
        dir_tab[0]  = '{CMD_WRITE,   6'd0,  6'd0,  32'd0,          1'b1, '0};
        dir_tab[1]  = '{CMD_WRITE,   6'd0,  6'd1,  32'h8000_0000,  1'b1, '0};
        dir_tab[2]  = '{CMD_WRITE,   6'd1,  6'd0,  32'h7FFF_FFFF,  1'b1, '0};
        dir_tab[3]  = '{CMD_WRITE,   6'd1,  6'd1,  32'd5,          1'b1, '0};
        dir_tab[4]  = '{CMD_WRITE,   6'd2,  6'd0,  32'd7,          1'b1, '0};
        dir_tab[5]  = '{CMD_WRITE,   6'd2,  6'd1,  32'h7FFF_FFFF,  1'b1, '0};
        dir_tab[6]  = '{CMD_WRITE,   6'd63, 6'd63, 32'hFFFF_FFFF,  1'b1, '0};
        dir_tab[7]  = '{CMD_UNUSED,  6'd63, 6'd63, 32'hFFFF_FFFF,  1'b1, '0};
        dir_tab[8]  = '{CMD_RESTART, 6'd0,  6'd0,  32'd0,          1'b1, '0};
        // signed compare: the most negative cell must lose
        dir_tab[9]  = '{CMD_STEP,    6'd0,  6'd0,  32'd0,          1'b0, '0};
        // equal maximum further down the window: stay and flag a peak
        dir_tab[10] = '{CMD_STEP,    6'd0,  6'd0,  32'd0,          1'b0, '0};
        dir_tab[11] = '{CMD_RESTART, 6'd0,  6'd0,  32'd0,          1'b1, '0};
        dir_tab[12] = '{CMD_WRITE,   6'd0,  6'd1,  32'd9,          1'b1, '0};
        dir_tab[13] = '{CMD_WRITE,   6'd1,  6'd0,  32'd9,          1'b1, '0};
        dir_tab[14] = '{CMD_WRITE,   6'd1,  6'd1,  32'd9,          1'b1, '0};
        // three-way tie: move to the first in row-major order
        dir_tab[15] = '{CMD_STEP,    6'd0,  6'd0,  32'd0,          1'b0, '0};
        dir_tab[16] = '{CMD_WRITE,   6'd0,  6'd2,  32'hFFFF_FFFB,  1'b1,
                        ghc_res_t'{32'd0, 6'd0, 6'd1, 1'b0}};
        dir_tab[17] = '{CMD_WRITE,   6'd1,  6'd2,  32'hFFFF_FFFB,  1'b1,
                        ghc_res_t'{32'd0, 6'd0, 6'd1, 1'b0}};
        dir_tab[18] = '{CMD_STEP,    6'd0,  6'd0,  32'd0,          1'b0, '0};
        dir_tab[19] = '{CMD_RESTART, 6'd0,  6'd0,  32'd0,          1'b1, '0};
        dir_tab[20] = '{CMD_WRITE,   6'd0,  6'd0,  32'h8000_0000,  1'b1, '0};
        dir_tab[21] = '{CMD_RESTART, 6'd0,  6'd0,  32'd0,          1'b1,
                        ghc_res_t'{32'h8000_0000, 6'd0, 6'd0, 1'b0}};

        // opening size settings: clamps, single row and column, shrink below
        // the position, full grid
        plan_rows = '{7'd4, 7'd0,   7'd127, 7'd1, 7'd64, 7'd8, 7'd2, 7'd65};
        plan_cols = '{7'd4, 7'd127, 7'd0,   7'd1, 7'd64, 7'd3, 7'd2, 7'd5};
        plan_ramp = '{1'b1, 1'b1,   1'b1,   1'b0, 1'b0,  1'b1, 1'b0, 1'b1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_cmd(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].col, dir_tab[i].val,
                     dir_tab[i].typed, dir_tab[i].want);

        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            // pick the size for this phase and write it while idle
            if (phase < PLAN_LEN)
            begin
                next_rows = plan_rows[phase];
                next_cols = plan_cols[phase];
                ramp_mode = plan_ramp[phase];
            end
            else
            begin
                next_rows = ($urandom_range(0, 99) < 70) ? CNT_W'($urandom_range(1, 10))
                                                          : CNT_W'($urandom_range(0, 127));
                next_cols = ($urandom_range(0, 99) < 70) ? CNT_W'($urandom_range(1, 10))
                                                          : CNT_W'($urandom_range(0, 127));
                ramp_mode = ($urandom_range(0, 1) == 1);
            end
            set_grid_size(next_rows, next_cols);
            calm = (phase == 2);

            // mostly climbs and restarts over written cells, some overwrites
            // and some dead commands
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_LEN)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    fill_then_send(CMD_STEP);
                else if (pick < 68)
                    fill_then_send(CMD_RESTART);
                else if (pick < 95)
                begin
                    if ($urandom_range(0, 99) < 60)
                    begin
                        wr_r = $urandom_range(0, eff_size(rows_raw, GRID_ROWS) - 1);
                        wr_c = $urandom_range(0, eff_size(cols_raw, GRID_COLS) - 1);
                    end
                    else
                    begin
                        wr_r = $urandom_range(0, GRID_ROWS - 1);
                        wr_c = $urandom_range(0, GRID_COLS - 1);
                    end
                    send_cmd(CMD_WRITE, POS_W'(wr_r), POS_W'(wr_c),
                             fresh_value(wr_r, wr_c), 1'b0, '0);
                end
                else
                    send_cmd(CMD_UNUSED, POS_W'($urandom_range(0, 63)),
                             POS_W'($urandom_range(0, 63)), $urandom, 1'b0, '0);
            end
            phase++;
        end

        settle();
        calm = 1'b0;
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
